// ===== design/rotary_encoder_accel_step_macros.svh =====
// Assertion macros used by the checker file of the encoder step block.
`ifndef ROTARY_ENCODER_ACCEL_STEP_MACROS_SVH
`define ROTARY_ENCODER_ACCEL_STEP_MACROS_SVH

// Checked property that is switched off while reset is high.
`define REAS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define REAS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/reas_pkg.sv =====
package reas_pkg;

  localparam int TICK_BITS_DEF = 32;

  localparam int RATE_W = 8;
  localparam int STEP_SIZE_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NOW_W = 32;
  localparam int OUT_STEP_W = 15;
  localparam int MAG_W = 14;
  localparam int LIN_W = 17;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CLICK_RATE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLICK_RATE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEP       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEP       = 2'd3;

  localparam logic [RATE_W-1:0]      MIN_CLICK_RATE_RST = 8'd20;
  localparam logic [RATE_W-1:0]      MAX_CLICK_RATE_RST = 8'd90;
  localparam logic [STEP_SIZE_W-1:0] MIN_STEP_RST       = 16'd1;
  localparam logic [STEP_SIZE_W-1:0] MAX_STEP_RST       = 16'd1000;

  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
  localparam logic [4:0]  SMOOTH_DIV   = 5'd20;
  localparam logic [12:0] SMOOTH_ROUND = 13'd19;

  typedef logic [MAG_W-1:0] mag_t;

  function automatic mag_t pow10_floor(input logic [LIN_W-1:0] v);
    mag_t p;
    if (v >= LIN_W'(10000)) begin
      p = MAG_W'(10000);
    end else if (v >= LIN_W'(1000)) begin
      p = MAG_W'(1000);
    end else if (v >= LIN_W'(100)) begin
      p = MAG_W'(100);
    end else if (v >= LIN_W'(10)) begin
      p = MAG_W'(10);
    end else begin
      p = MAG_W'(1);
    end
    return p;
  endfunction

endpackage

// ===== design/rotary_encoder_accel_step.sv =====
// Rotary encoder step generator with velocity acceleration.
// The slave stream carries one transaction per level change on encoder line A:
// a_level, b_level and the millisecond tick now_ms. Only a falling A edge
// produces a master transaction holding a signed power-of-ten step; a rising
// edge is absorbed and leaves s_tready high. The first click after reset gives +1 or -1.
// Later clicks run through one serial arithmetic engine: a restoring divider
// that retires one quotient bit per cycle and a shift-add multiplier that
// consumes one multiplier bit per cycle. A full click runs, in order, the 1000/dt
// division, the smoothing division, four cube multiplies, the span multiply and
// the final division, then sets the step and hands it to the output register;
// the first click goes straight to the output, and an empty rate range skips the
// multiplies and the final division. One click is processed at a time;
// s_tready is high only while the engine is idle.
// A finished step waits in the output register, so the next click may be
// accepted while the receiver stalls, and the engine holds its result until
// the output register is free.
// Reset (rst, synchronous) restores the register defaults, forgets the last
// click and clears the smoothed rate. Configuration writes are taken at once
// and must only happen while the block is idle.
module rotary_encoder_accel_step
  import reas_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // a_level [0], b_level [1], now_ms [33:2], zero fill [39:34]
  input  logic [S_TDATA_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // step [14:0], zero fill [15]
  output logic [M_TDATA_W-1:0]   m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDIV  = 4'd1;
  localparam logic [3:0] S_RATE  = 4'd2;
  localparam logic [3:0] S_SDIV  = 4'd3;
  localparam logic [3:0] S_R2    = 4'd4;
  localparam logic [3:0] S_R3    = 4'd5;
  localparam logic [3:0] S_S2    = 4'd6;
  localparam logic [3:0] S_S3    = 4'd7;
  localparam logic [3:0] S_SPAN  = 4'd8;
  localparam logic [3:0] S_QDIV  = 4'd9;
  localparam logic [3:0] S_LIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam int ACC_W = 40;
  localparam int MCAND_W = 24;
  localparam int REM_W = 24;

  logic [3:0]             state;
  logic [5:0]             cnt;
  logic [RATE_W-1:0]      min_click_rate;
  logic [RATE_W-1:0]      max_click_rate;
  logic [STEP_SIZE_W-1:0] min_step;
  logic [STEP_SIZE_W-1:0] max_step;
  logic [TICK_BITS-1:0]   last_click_time;
  logic                   have_click;
  logic [RATE_W-1:0]      smoothed_rate;
  logic                   neg;
  logic [OUT_STEP_W-1:0]  result;
  logic [OUT_STEP_W-1:0]  step_q;

  logic [ACC_W-1:0]       acc;
  logic [MCAND_W-1:0]     mcand;
  logic [15:0]            mplier;
  logic [ACC_W-1:0]       dvd;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       divisor;

  logic                   in_fire;
  logic                   a_level;
  logic                   b_level;
  logic [TICK_BITS-1:0]   now_t;
  logic [TICK_BITS-1:0]   dt;
  logic [RATE_W-1:0]      hi;
  logic [RATE_W-1:0]      range;
  logic [RATE_W-1:0]      s_clip;
  logic [STEP_SIZE_W-1:0] span;
  logic [ACC_W-1:0]       acc_step;
  logic [15:0]            mplier_step;
  logic [REM_W:0]         trial;
  logic [REM_W:0]         trial_diff;
  logic                   q_bit;
  logic [REM_W-1:0]       rem_step;
  logic [ACC_W-1:0]       dvd_step;
  logic [9:0]             raw_c1;
  logic [9:0]             raw_c2;
  logic [RATE_W-1:0]      raw;
  logic [12:0]            smooth_num;
  logic [LIN_W-1:0]       lin;
  mag_t                   mag;
  logic                   last_step;
  logic                   out_free;

  assign a_level = s_tdata[0];
  assign b_level = s_tdata[1];
  assign now_t   = TICK_BITS'(s_tdata[NOW_W+1:2]);
  assign dt      = now_t - last_click_time;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tdata  = {1'b0, step_q};
  assign out_free = !m_tvalid || m_tready;

  assign hi     = (max_click_rate > min_click_rate) ? max_click_rate : min_click_rate;
  assign range  = hi - min_click_rate;
  assign s_clip = (smoothed_rate < range) ? smoothed_rate : range;
  assign span   = (max_step > min_step) ? (max_step - min_step) : '0;

  assign last_step = (cnt == 6'd1);

  always_comb begin
    acc_step    = {acc[ACC_W-2:0], 1'b0} + (mplier[15] ? ACC_W'(mcand) : '0);
    mplier_step = {mplier[14:0], 1'b0};
    trial       = {rem, dvd[ACC_W-1]};
    trial_diff  = trial - {1'b0, divisor};
    q_bit       = (trial >= {1'b0, divisor});
    rem_step    = q_bit ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
    dvd_step    = {dvd[ACC_W-2:0], q_bit};
  end

  always_comb begin
    raw_c1 = (dvd[9:0] < {2'b0, min_click_rate}) ? {2'b0, min_click_rate} : dvd[9:0];
    raw_c2 = (raw_c1 > {2'b0, hi}) ? {2'b0, hi} : raw_c1;
    raw    = RATE_W'(raw_c2 - {2'b0, min_click_rate});
    smooth_num = 13'(smoothed_rate) + (13'(raw) << 4) + (13'(raw) << 1) + 13'(raw)
                 + SMOOTH_ROUND;
    lin = {1'b0, dvd[15:0]} + {1'b0, min_step};
    mag = pow10_floor(lin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_click_rate <= MIN_CLICK_RATE_RST;
      max_click_rate <= MAX_CLICK_RATE_RST;
      min_step       <= MIN_STEP_RST;
      max_step       <= MAX_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_CLICK_RATE: min_click_rate <= cfg_data[RATE_W-1:0];
        REG_MAX_CLICK_RATE: max_click_rate <= cfg_data[RATE_W-1:0];
        REG_MIN_STEP:       min_step       <= cfg_data;
        REG_MAX_STEP:       max_step       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      step_q <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt             <= '0;
      have_click      <= 1'b0;
      smoothed_rate   <= '0;
      last_click_time <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && !a_level) begin
            neg             <= b_level;
            last_click_time <= now_t;
            have_click      <= 1'b1;
            if (!have_click) begin
              result <= b_level ? {OUT_STEP_W{1'b1}} : OUT_STEP_W'(1);
              state  <= S_OUT;
            end else if (dt == '0) begin
              dvd   <= ACC_W'(max_click_rate);
              state <= S_RATE;
            end else if (dt > TICK_BITS'(MS_PER_SEC)) begin
              dvd   <= ACC_W'(1);
              state <= S_RATE;
            end else begin
              dvd     <= {MS_PER_SEC, 30'b0};
              divisor <= REM_W'(dt[9:0]);
              rem     <= '0;
              cnt     <= 6'd10;
              state   <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          dvd <= dvd_step;
          rem <= rem_step;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            state <= S_RATE;
          end
        end
        S_RATE: begin
          dvd     <= {smooth_num, 27'b0};
          divisor <= REM_W'(SMOOTH_DIV);
          rem     <= '0;
          cnt     <= 6'd13;
          state   <= S_SDIV;
        end
        S_SDIV: begin
          rem <= rem_step;
          if (!last_step) begin
            dvd <= dvd_step;
            cnt <= cnt - 6'd1;
          end else begin
            smoothed_rate <= dvd_step[RATE_W-1:0];
            if (range == '0) begin
              dvd   <= '0;
              state <= S_LIN;
            end else begin
              acc    <= '0;
              mcand  <= MCAND_W'(range);
              mplier <= {range, 8'b0};
              cnt    <= 6'd8;
              state  <= S_R2;
            end
          end
        end
        S_R2, S_R3, S_S2, S_S3, S_SPAN: begin
          if (!last_step) begin
            acc    <= acc_step;
            mplier <= mplier_step;
            cnt    <= cnt - 6'd1;
          end else begin
            unique case (state)
              S_R2: begin
                acc    <= '0;
                cnt    <= 6'd8;
                mcand  <= acc_step[MCAND_W-1:0];
                mplier <= {range, 8'b0};
                state  <= S_R3;
              end
              S_R3: begin
                acc     <= '0;
                cnt     <= 6'd8;
                divisor <= acc_step[REM_W-1:0];
                mcand   <= MCAND_W'(s_clip);
                mplier  <= {s_clip, 8'b0};
                state   <= S_S2;
              end
              S_S2: begin
                acc    <= '0;
                cnt    <= 6'd8;
                mcand  <= acc_step[MCAND_W-1:0];
                mplier <= {s_clip, 8'b0};
                state  <= S_S3;
              end
              S_S3: begin
                acc    <= '0;
                mcand  <= acc_step[MCAND_W-1:0];
                mplier <= span;
                cnt    <= 6'd16;
                state  <= S_SPAN;
              end
              default: begin
                dvd   <= acc_step;
                rem   <= '0;
                cnt   <= 6'd40;
                state <= S_QDIV;
              end
            endcase
          end
        end
        S_QDIV: begin
          dvd <= dvd_step;
          rem <= rem_step;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            state <= S_LIN;
          end
        end
        S_LIN: begin
          result <= neg ? (OUT_STEP_W'(0) - OUT_STEP_W'(mag)) : OUT_STEP_W'(mag);
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/reas_checker.sv =====
`include "rotary_encoder_accel_step_macros.svh"

module reas_checker
  import reas_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [S_TDATA_W-1:0]   s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_TDATA_W-1:0]   m_tdata
);

  logic pow10_step;

  assign pow10_step =
      (m_tdata[14:0] == 15'd1)    || (m_tdata[14:0] == 15'd10)   ||
      (m_tdata[14:0] == 15'd100)  || (m_tdata[14:0] == 15'd1000) ||
      (m_tdata[14:0] == 15'd10000) ||
      (m_tdata[14:0] == 15'h7FFF) || (m_tdata[14:0] == 15'h7FF6) ||
      (m_tdata[14:0] == 15'h7F9C) || (m_tdata[14:0] == 15'h7C18) ||
      (m_tdata[14:0] == 15'h58F0);

  `REAS_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "output transaction changed while stalled")
  `REAS_ASSERT_ALWAYS(a_reset_empty, clk, ($past(rst) |-> !m_tvalid), "output valid right after reset")
  `REAS_ASSERT(a_pow10, clk, rst, (m_tvalid |-> pow10_step), "step is not a signed power of ten")
  `REAS_ASSERT(a_busy_after_click, clk, rst, (s_tvalid && s_tready && !s_tdata[0] |=> !s_tready), "input still ready after a falling edge")
  `REAS_ASSERT(a_rise_absorbed, clk, rst, (s_tvalid && s_tready && s_tdata[0] |=> s_tready), "rising edge stalled the input")

endmodule

bind rotary_encoder_accel_step reas_checker u_reas_checker (.*);

// ===== sim/rotary_encoder_accel_step_test.sv =====
module rotary_encoder_accel_step_test;
  import reas_pkg::*;

  localparam int LATENCY_SLACK = 150;
  localparam int LIMIT_CYCLES = 600000;

  class step_tracker;
    logic [OUT_STEP_W-1:0] steps_due[$];
    int errors;
    logic [RATE_W-1:0] lo_rate;
    logic [RATE_W-1:0] hi_rate;
    logic [STEP_SIZE_W-1:0] lo_size;
    logic [STEP_SIZE_W-1:0] hi_size;
    logic [NOW_W-1:0] last_ms;
    bit have_click;
    logic [RATE_W-1:0] smooth;

    function new();
      errors = 0;
      lo_rate = MIN_CLICK_RATE_RST;
      hi_rate = MAX_CLICK_RATE_RST;
      lo_size = MIN_STEP_RST;
      hi_size = MAX_STEP_RST;
      last_ms = '0;
      have_click = 1'b0;
      smooth = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_CLICK_RATE: lo_rate = data[RATE_W-1:0];
        REG_MAX_CLICK_RATE: hi_rate = data[RATE_W-1:0];
        REG_MIN_STEP: lo_size = data[STEP_SIZE_W-1:0];
        REG_MAX_STEP: hi_size = data[STEP_SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // Predicts the step for one accepted edge; rising edges leave everything untouched.
    function void note_edge(bit a, bit b, logic [NOW_W-1:0] now_ms);
      logic [NOW_W-1:0] dt;
      longint unsigned top, range, raw, sv, span, lin, mag;
      if (a) return;
      mag = 1;
      if (have_click) begin
        dt = now_ms - last_ms;
        top = (hi_rate > lo_rate) ? 64'(hi_rate) : 64'(lo_rate);
        range = top - lo_rate;
        if (dt == 0) begin
          raw = 64'(hi_rate);
        end else begin
          raw = 1000 / longint'(dt);
          if (raw < 1) raw = 1;
        end
        if (raw < lo_rate) raw = 64'(lo_rate);
        if (raw > top) raw = top;
        raw = raw - lo_rate;
        smooth = RATE_W'((longint'(smooth) + 19 * raw + 19) / 20);
        span = (hi_size > lo_size) ? longint'(hi_size) - longint'(lo_size) : 0;
        sv = (smooth < range) ? 64'(smooth) : range;
        if (range == 0) lin = 64'(lo_size);
        else lin = (sv * sv * sv * span) / (range * range * range) + lo_size;
        while (mag <= lin / 10) mag = mag * 10;
      end
      last_ms = now_ms;
      have_click = 1'b1;
      steps_due.push_back(b ? OUT_STEP_W'(32768 - mag) : OUT_STEP_W'(mag));
    endfunction

    function void check_step(logic [OUT_STEP_W-1:0] got);
      logic [OUT_STEP_W-1:0] want;
      if (steps_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("step %0d arrived with none expected", $signed(got));
        return;
      end
      want = steps_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("step mismatch: expected %0d, got %0d", $signed(want),
                                   $signed(got));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  step_tracker sb = new();
  logic [NOW_W-1:0] tick = '0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  rotary_encoder_accel_step dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_step(m_tdata[OUT_STEP_W-1:0]);
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic put_item(bit a, bit b, logic [NOW_W-1:0] now_ms);
    if (!calm && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {(S_TDATA_W - NOW_W - 2)'(0), now_ms, b, a};
    do @(posedge clk); while (!s_tready);
    sb.note_edge(a, b, now_ms);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.steps_due.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [RATE_W-1:0] lo_rate, logic [RATE_W-1:0] hi_rate,
                            logic [STEP_SIZE_W-1:0] lo_size, logic [STEP_SIZE_W-1:0] hi_size);
    cfg_we <= 1'b1;
    put_reg(REG_MIN_CLICK_RATE, {8'($urandom_range(0, 255)), lo_rate});
    put_reg(REG_MAX_CLICK_RATE, {8'($urandom_range(0, 255)), hi_rate});
    put_reg(REG_MIN_STEP, lo_size);
    put_reg(REG_MAX_STEP, hi_size);
    cfg_we <= 1'b0;
  endtask

  task automatic fast_burst(int clicks);
    repeat (clicks) begin
      put_item(1'b1, 1'b0, tick);
      tick += 1;
      put_item(1'b0, 1'b0, tick);
    end
  endtask

  task automatic run_clicks(int n);
    int done;
    int pace;
    bit dir;
    logic [NOW_W-1:0] dt;
    done = 0;
    while (done < n) begin
      pace = $urandom_range(0, 9);
      dir = 1'($urandom_range(0, 1));
      repeat ($urandom_range(3, 15)) begin
        if (done >= n) break;
        case (pace)
          0, 1: dt = $urandom_range(0, 4);
          2, 3: dt = $urandom_range(5, 20);
          4, 5: dt = $urandom_range(20, 120);
          6, 7: dt = $urandom_range(100, 1100);
          8: dt = $urandom_range(0, 60000);
          default: dt = $urandom();
        endcase
        if ($urandom_range(0, 99) < 8) begin
          put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
          done += 1;
        end else begin
          put_item(1'b1, 1'($urandom_range(0, 1)), tick + dt / 2);
          tick += dt;
          put_item(1'b0, dir ^ ($urandom_range(0, 9) == 0), tick);
          done += 2;
        end
      end
    end
  endtask

  task automatic phase(logic [RATE_W-1:0] lo_rate, logic [RATE_W-1:0] hi_rate,
                       logic [STEP_SIZE_W-1:0] lo_size, logic [STEP_SIZE_W-1:0] hi_size,
                       int n);
    settle();
    set_config(lo_rate, hi_rate, lo_size, hi_size);
    run_clicks(n);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    put_item(1'b1, 1'b0, 32'd0);
    put_item(1'b0, 1'b0, 32'd0);
    put_item(1'b1, 1'b1, 32'd5);
    put_item(1'b0, 1'b1, 32'd5);
    put_item(1'b0, 1'b0, 32'd5);
    put_item(1'b0, 1'b1, 32'd6);
    put_item(1'b0, 1'b0, 32'd2006);
    put_item(1'b0, 1'b0, 32'd3006);
    put_item(1'b0, 1'b1, 32'd4005);
    put_item(1'b0, 1'b0, 32'd4016);
    put_item(1'b0, 1'b0, 32'd4028);
    put_item(1'b0, 1'b1, 32'd4038);
    put_item(1'b0, 1'b0, 32'd4048);
    put_item(1'b0, 1'b1, 32'd4058);
    put_item(1'b1, 1'b1, 32'hFFFF_FFFF);
    put_item(1'b0, 1'b1, 32'hFFFF_FFFE);
    put_item(1'b0, 1'b0, 32'hFFFF_FFFF);
    put_item(1'b0, 1'b1, 32'd3);
    put_item(1'b0, 1'b0, 32'd50);

    tick = $urandom();
    phase(8'd0, 8'd255, 16'd1, 16'd65535, 55);
    fast_burst(12);
    phase(8'd0, 8'd10, 16'd1, 16'd10000, 55);
    settle();
    set_config(8'd20, 8'd90, 16'd1, 16'd1000);
    hold_req = 1'b1;
    run_clicks(55);
    settle();
    calm = 1'b1;
    set_config(8'd254, 8'd255, 16'd1, 16'd65535);
    run_clicks(55);
    calm = 1'b0;
    phase(8'd200, 8'd100, 16'd7, 16'd9000, 50);
    phase(8'd50, 8'd50, 16'd1, 16'd1000, 40);
    phase(8'd10, 8'd200, 16'd5000, 16'd10, 50);
    phase(8'd0, 8'd1, 16'd0, 16'd0, 40);
    phase(8'd5, 8'd250, 16'd0, 16'd65535, 55);
    phase(8'd30, 8'd120, 16'd65535, 16'd65535, 45);
    hold_req = 1'b1;
    phase(8'($urandom_range(0, 254)), 8'($urandom_range(1, 255)),
          16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 55);
    phase(8'($urandom_range(0, 100)), 8'($urandom_range(60, 255)),
          16'($urandom_range(0, 50)), 16'($urandom_range(1, 65535)), 55);
    settle();

    if (sb.errors == 0 && sb.steps_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/reas_pkg.sv
design/rotary_encoder_accel_step.sv
design/reas_checker.sv
sim/rotary_encoder_accel_step_test.sv
